@@ hdl/plid_pkg.sv @@
// Package: sizes, codes and shared types of the positional list core.
`default_nettype none
package plid_pkg;

   localparam int DEPTH    = 16;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W    = 5;
   localparam int LEN_W    = 5;
   localparam int DATA_W   = 32;
   localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

   typedef enum logic [1:0] {
      FN_INSERT = 2'd0,
      FN_DELETE = 2'd1,
      FN_READ   = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_INS_STEP,
      S_INS_MOVE,
      S_DEL_STEP,
      S_DEL_MOVE,
      S_RD_WAIT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [DATA_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_req_type;

endpackage
`default_nettype wire

@@ hdl/plid_if.sv @@
// Interfaces: request and response channels of the positional list core.
`default_nettype none
interface plid_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          func;
   logic [plid_pkg::POS_W-1:0]          position;
   logic signed [plid_pkg::DATA_W-1:0]  value;

   modport source (output valid, output func, output position, output value, input ready);
   modport sink   (input valid, input func, input position, input value, output ready);
endinterface

interface plid_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          status;
   logic signed [plid_pkg::DATA_W-1:0]  read_value;
   logic [plid_pkg::LEN_W-1:0]          list_length;

   modport source (output valid, output status, output read_value, output list_length,
                   input ready);
   modport sink   (input valid, input status, input read_value, input list_length,
                   output ready);
endinterface
`default_nettype wire

@@ hdl/positional_list_insert_delete_core.sv @@
// Top level: sequencer that edits the positional list one entry move at a time.
//
//   channel  | direction | handshake      | payload
//   req_ch   | in        | valid / ready  | func, position, value
//   rsp_ch   | out       | valid / ready  | status, read_value, list_length
//
// Each moved entry is read in a step state and then written one slot over in a
// move state, as the entry memory has a single write port and a single
// registered read port. A read captures its data in S_RD_WAIT; a rejected
// transaction goes straight to the response. Synchronous reset empties
// the list; entry contents are not cleared. One transaction is in flight at a
// time: req_ch.ready is low from acceptance until the response is taken.
`default_nettype none
module positional_list_insert_delete_core (
   input  wire         clock,
   input  wire         reset,
   plid_req_if.sink    req_ch,
   plid_rsp_if.source  rsp_ch
);

   localparam int CMP_W  = plid_pkg::CMP_W;
   localparam int ADDR_W = plid_pkg::ADDR_W;

   plid_pkg::state_type                 state_ff, state_in;
   logic [plid_pkg::COUNT_W-1:0]        count_ff, count_in;
   logic [CMP_W-1:0]                    idx_ff, idx_in;
   logic [CMP_W-1:0]                    pos_ff, pos_in;
   logic signed [plid_pkg::DATA_W-1:0]  val_ff, val_in;
   plid_pkg::status_type                status_ff, status_in;
   logic signed [plid_pkg::DATA_W-1:0]  rdval_ff, rdval_in;

   plid_pkg::mem_req_type               mem_req;
   logic [plid_pkg::DATA_W-1:0]         mem_rdata;

   logic                                req_fire;
   logic [CMP_W-1:0]                    cnt_x;
   logic [CMP_W-1:0]                    req_pos_x;
   logic [CMP_W-1:0]                    idx_m1;

   plid_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rdata   (mem_rdata)
   );

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign cnt_x     = CMP_W'(count_ff);
   assign req_pos_x = CMP_W'(req_ch.position);
   assign idx_m1    = idx_ff - 1'b1;

   assign req_ch.ready       = (state_ff == plid_pkg::S_IDLE);
   assign rsp_ch.valid       = (state_ff == plid_pkg::S_RESP);
   assign rsp_ch.status      = status_ff;
   assign rsp_ch.read_value  = rdval_ff;
   assign rsp_ch.list_length = cnt_x[plid_pkg::LEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= plid_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      status_ff <= status_in;
      rdval_ff  <= rdval_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      val_in    = val_ff;
      status_in = status_ff;
      rdval_in  = rdval_ff;
      mem_req   = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};

      case (state_ff)
         plid_pkg::S_IDLE: begin
            if (req_fire) begin
               pos_in    = req_pos_x;
               val_in    = req_ch.value;
               rdval_in  = '0;
               status_in = plid_pkg::ST_OK;
               case (req_ch.func)
                  plid_pkg::FN_INSERT: begin
                     if (req_pos_x > cnt_x) begin
                        status_in = plid_pkg::ST_RANGE;
                        state_in  = plid_pkg::S_RESP;
                     end else if (cnt_x >= CMP_W'(plid_pkg::DEPTH)) begin
                        status_in = plid_pkg::ST_FULL;
                        state_in  = plid_pkg::S_RESP;
                     end else begin
                        idx_in   = cnt_x;
                        state_in = plid_pkg::S_INS_STEP;
                     end
                  end
                  plid_pkg::FN_DELETE: begin
                     if (req_pos_x >= cnt_x) begin
                        status_in = plid_pkg::ST_RANGE;
                        state_in  = plid_pkg::S_RESP;
                     end else begin
                        idx_in   = req_pos_x + 1'b1;
                        state_in = plid_pkg::S_DEL_STEP;
                     end
                  end
                  plid_pkg::FN_READ: begin
                     if (req_pos_x >= cnt_x) begin
                        status_in = plid_pkg::ST_RANGE;
                        state_in  = plid_pkg::S_RESP;
                     end else begin
                        mem_req.raddr = req_pos_x[ADDR_W-1:0];
                        state_in      = plid_pkg::S_RD_WAIT;
                     end
                  end
                  default: begin
                     status_in = plid_pkg::ST_RANGE;
                     state_in  = plid_pkg::S_RESP;
                  end
               endcase
            end
         end
         // walk down from the tail, opening a gap at pos
         plid_pkg::S_INS_STEP: begin
            if (idx_ff == pos_ff) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = pos_ff[ADDR_W-1:0];
               mem_req.wdata = val_ff;
               count_in      = count_ff + 1'b1;
               state_in      = plid_pkg::S_RESP;
            end else begin
               mem_req.raddr = idx_m1[ADDR_W-1:0];
               state_in      = plid_pkg::S_INS_MOVE;
            end
         end
         plid_pkg::S_INS_MOVE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff[ADDR_W-1:0];
            mem_req.wdata = mem_rdata;
            idx_in        = idx_m1;
            state_in      = plid_pkg::S_INS_STEP;
         end
         // walk up from pos+1, closing the gap
         plid_pkg::S_DEL_STEP: begin
            if (idx_ff == cnt_x) begin
               count_in = count_ff - 1'b1;
               state_in = plid_pkg::S_RESP;
            end else begin
               mem_req.raddr = idx_ff[ADDR_W-1:0];
               state_in      = plid_pkg::S_DEL_MOVE;
            end
         end
         plid_pkg::S_DEL_MOVE: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_m1[ADDR_W-1:0];
            mem_req.wdata = mem_rdata;
            idx_in        = idx_ff + 1'b1;
            state_in      = plid_pkg::S_DEL_STEP;
         end
         plid_pkg::S_RD_WAIT: begin
            rdval_in = mem_rdata;
            state_in = plid_pkg::S_RESP;
         end
         plid_pkg::S_RESP: begin
            if (rsp_ch.ready) begin
               state_in = plid_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = plid_pkg::S_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_x <= CMP_W'(plid_pkg::DEPTH))
      else $error("list length exceeds capacity");

   a_idle_count_stable: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plid_pkg::S_IDLE && !req_fire) |=> $stable(count_ff))
      else $error("list length changed without a transaction");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("request accepted while a response is pending");

   a_err_zero_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && status_ff != plid_pkg::ST_OK) |-> (rdval_ff == '0))
      else $error("nonzero read value on a failed transaction");

   a_ins_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == plid_pkg::S_INS_MOVE) |-> (idx_ff <= cnt_x && idx_ff > pos_ff))
      else $error("insert move index out of range");

endmodule
`default_nettype wire

@@ hdl/plid_mem.sv @@
// Entry storage: one write port and one registered read port.
`default_nettype none
module plid_mem (
   input  wire                                 clock,
   input  plid_pkg::mem_req_type               mem_req,
   output logic [plid_pkg::DATA_W-1:0]         rdata
);

   logic [plid_pkg::DATA_W-1:0] store [plid_pkg::DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         store[mem_req.waddr] <= mem_req.wdata;
      end
   end

   always_ff @(posedge clock) begin
      rdata <= store[mem_req.raddr];
   end

endmodule
`default_nettype wire

@@ dv/tb_positional_list_insert_delete_core.sv @@
// Testbench: positional list core checked against a queue-based list predictor.
module tb_positional_list_insert_delete_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH  = plid_pkg::DEPTH;
   localparam int POS_W  = plid_pkg::POS_W;
   localparam int LEN_W  = plid_pkg::LEN_W;
   localparam int DATA_W = plid_pkg::DATA_W;

   localparam logic [1:0] FN_UNUSED = 2'd3;
   localparam int RANDOM_OPS    = 2000;
   localparam int DIRECTED_ROWS = 24;
   localparam int TAIL_CYCLES   = 2 * DEPTH + 4;

   localparam logic [1:0] RX_STEADY = 2'd0;
   localparam logic [1:0] RX_COIN   = 2'd1;
   localparam logic [1:0] RX_SPARSE = 2'd2;
   localparam logic [1:0] RX_LIGHT  = 2'd3;

   typedef struct packed {
      plid_pkg::status_type status;
      logic [DATA_W-1:0]    read_value;
      logic [LEN_W-1:0]     list_length;
   } list_outcome_type;

   typedef struct {
      logic [1:0]          fn;
      logic [POS_W-1:0]    pos;
      logic [DATA_W-1:0]   val;
      int                  reps;
      bit                  append;
      bit                  typed;
      list_outcome_type    outcome;
   } list_op_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic [7:0] stall_cycle = '0;
   int error_count = 0;

   logic [DATA_W-1:0] list_entries[$];
   list_outcome_type pending_outcomes[$];

   plid_req_if req_ch ();
   plid_rsp_if rsp_ch ();

   positional_list_insert_delete_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Rows with typed outcomes follow the list contents step by step from reset.
   list_op_row_type directed_ops [0:DIRECTED_ROWS-1] = '{
      '{plid_pkg::FN_READ,   5'd0,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd0}},
      '{plid_pkg::FN_DELETE, 5'd0,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd0}},
      '{plid_pkg::FN_INSERT, 5'd1,  32'h5555_5555, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd0}},
      '{FN_UNUSED,           5'd0,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd0}},
      '{plid_pkg::FN_INSERT, 5'd0,  32'h7FFF_FFFF, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'd0, 5'd1}},
      '{plid_pkg::FN_READ,   5'd0,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'h7FFF_FFFF, 5'd1}},
      '{plid_pkg::FN_INSERT, 5'd1,  32'h8000_0000, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'd0, 5'd2}},
      '{plid_pkg::FN_READ,   5'd1,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'h8000_0000, 5'd2}},
      '{plid_pkg::FN_INSERT, 5'd0,  32'hFFFF_FFFF, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'd0, 5'd3}},
      '{plid_pkg::FN_READ,   5'd0,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'hFFFF_FFFF, 5'd3}},
      '{plid_pkg::FN_READ,   5'd3,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd3}},
      '{plid_pkg::FN_INSERT, 5'd4,  32'h1234_5678, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd3}},
      '{plid_pkg::FN_INSERT, 5'd0,  32'd0,        13, 1'b1, 1'b0,
        '{plid_pkg::ST_OK, 32'd0, 5'd0}},
      '{plid_pkg::FN_INSERT, 5'd16, 32'hA5A5_A5A5, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_FULL, 32'd0, 5'd16}},
      '{plid_pkg::FN_INSERT, 5'd17, 32'hA5A5_A5A5, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd16}},
      '{plid_pkg::FN_READ,   5'd16, 32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd16}},
      '{plid_pkg::FN_READ,   5'd2,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'h8000_0000, 5'd16}},
      '{plid_pkg::FN_DELETE, 5'd31, 32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd16}},
      '{plid_pkg::FN_DELETE, 5'd0,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'd0, 5'd15}},
      '{plid_pkg::FN_READ,   5'd0,  32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'h7FFF_FFFF, 5'd15}},
      '{plid_pkg::FN_DELETE, 5'd14, 32'd0,         1, 1'b0, 1'b1,
        '{plid_pkg::ST_OK, 32'd0, 5'd14}},
      '{plid_pkg::FN_READ,   5'd13, 32'd0,         1, 1'b0, 1'b0,
        '{plid_pkg::ST_OK, 32'd0, 5'd0}},
      '{FN_UNUSED,           5'd31, 32'hFFFF_FFFF, 1, 1'b0, 1'b1,
        '{plid_pkg::ST_RANGE, 32'd0, 5'd14}},
      '{plid_pkg::FN_INSERT, 5'd5,  32'h0F0F_F0F0, 1, 1'b0, 1'b0,
        '{plid_pkg::ST_OK, 32'd0, 5'd0}}
   };

   // Apply one operation to the predicted list and return the outcome it gives.
   function automatic list_outcome_type apply_list_op(input logic [1:0] fn,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [DATA_W-1:0] val);
      list_outcome_type outcome;
      int held;
      int slot;
      outcome.status = plid_pkg::ST_OK;
      outcome.read_value = '0;
      held = list_entries.size();
      slot = int'(pos);
      case (fn)
         plid_pkg::FN_INSERT: begin
            if (slot > held) outcome.status = plid_pkg::ST_RANGE;
            else if (held >= DEPTH) outcome.status = plid_pkg::ST_FULL;
            else list_entries.insert(slot, val);
         end
         plid_pkg::FN_DELETE: begin
            if (slot >= held) outcome.status = plid_pkg::ST_RANGE;
            else list_entries.delete(slot);
         end
         plid_pkg::FN_READ: begin
            if (slot >= held) outcome.status = plid_pkg::ST_RANGE;
            else outcome.read_value = list_entries[slot];
         end
         default: outcome.status = plid_pkg::ST_RANGE;
      endcase
      outcome.list_length = LEN_W'(list_entries.size());
      return outcome;
   endfunction

   function automatic logic [DATA_W-1:0] draw_entry_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         default: return $urandom;
      endcase
   endfunction

   // Drive one transaction and hold it until accepted, then record its outcome.
   task automatic send_op(input logic [1:0] fn, input logic [POS_W-1:0] pos,
                          input logic [DATA_W-1:0] val, input bit typed,
                          input list_outcome_type typed_outcome);
      list_outcome_type predicted;
      req_ch.valid    <= 1'b1;
      req_ch.func     <= fn;
      req_ch.position <= pos;
      req_ch.value    <= val;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = apply_list_op(fn, pos, val);
      pending_outcomes.push_back(typed ? typed_outcome : predicted);
   endtask

   // Receiver stall pattern: cycle through four phases chosen by stall_cycle[7:6].
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 8'd1;
      case (stall_cycle[7:6])
         RX_STEADY: rsp_ch.ready <= 1'b1;
         RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
         RX_SPARSE: rsp_ch.ready <= (stall_cycle[1:0] == 2'd0);
         RX_LIGHT:  rsp_ch.ready <= ($urandom_range(0, 9) != 0);
         default:   rsp_ch.ready <= 1'b1;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected transaction: status %0d read_value %h list_length %0d",
                     $time, rsp_ch.status, rsp_ch.read_value, rsp_ch.list_length);
            error_count++;
         end else begin
            list_outcome_type want;
            want = pending_outcomes.pop_front();
            if (rsp_ch.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h",
                        $time, want.read_value, rsp_ch.read_value);
               error_count++;
            end
            if (rsp_ch.list_length !== want.list_length) begin
               $display("%0t: list_length expected %0d actual %0d",
                        $time, want.list_length, rsp_ch.list_length);
               error_count++;
            end
         end
      end
   end

   initial begin : stimulus
      int burst_left;
      int gap;
      int phase_left;
      int held;
      bit grow;
      logic [1:0] fn;
      logic [POS_W-1:0] pos;
      logic [DATA_W-1:0] val;
      list_outcome_type unused_outcome;

      unused_outcome = '0;
      req_ch.valid    = 1'b0;
      req_ch.func     = plid_pkg::FN_INSERT;
      req_ch.position = '0;
      req_ch.value    = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_ops[i]) begin
         for (int r = 0; r < directed_ops[i].reps; r++) begin
            if (directed_ops[i].append)
               send_op(directed_ops[i].fn, POS_W'(list_entries.size()), draw_entry_value(),
                       1'b0, unused_outcome);
            else
               send_op(directed_ops[i].fn, directed_ops[i].pos, directed_ops[i].val,
                       directed_ops[i].typed, directed_ops[i].outcome);
         end
      end

      burst_left = 0;
      phase_left = 0;
      grow = 1'b1;
      for (int n = 0; n < RANDOM_OPS; n++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
               req_ch.valid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 12);
         end
         burst_left--;

         // Alternate between filling and draining so both ends of the list are hit.
         if (phase_left == 0) begin
            grow = ~grow;
            phase_left = $urandom_range(20, 60);
         end
         phase_left--;

         held = list_entries.size();
         val = draw_entry_value();
         if ($urandom_range(0, 99) < 8) begin
            fn  = 2'($urandom_range(0, 3));
            pos = POS_W'($urandom_range(0, 31));
         end else begin
            if (held == 0)
               fn = plid_pkg::FN_INSERT;
            else if ($urandom_range(0, 99) < 35)
               fn = plid_pkg::FN_READ;
            else if ($urandom_range(0, 99) < (grow ? 75 : 25))
               fn = plid_pkg::FN_INSERT;
            else
               fn = plid_pkg::FN_DELETE;
            if (fn == plid_pkg::FN_INSERT)
               pos = POS_W'($urandom_range(0, held));
            else
               pos = POS_W'($urandom_range(0, held - 1));
         end
         send_op(fn, pos, val, 1'b0, unused_outcome);
      end
      req_ch.valid <= 1'b0;

      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("positional_list_insert_delete_core test passed");
      end else begin
         $display("positional_list_insert_delete_core test failed");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("positional_list_insert_delete_core test failed");
      $finish;
   end

endmodule
